### hdl/ffsa_pkg.sv
// shared types, constants and codes of the first-fit segment allocator
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int POOL_WORDS   = 8192;
  localparam int MAX_SEGMENTS = 32;

  localparam int START_W = 13;
  localparam int LEN_W   = 14;
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_ROTATE,
    CC_WRITE,
    CC_SPLIT,
    CC_MERGE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EDIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               used;
  } entry_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] pos;
    entry_t           ent_a;
    entry_t           ent_b;
    logic [1:0]       shift;
  } cell_ctl_t;

endpackage

### hdl/ffsa_req_if.sv
// request channel: operation, size and block address
`timescale 1ns / 1ps
interface ffsa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [13:0] request_words;
  logic [12:0] block_start;

  modport source (output valid, operation, request_words, block_start, input ready);
  modport sink   (input valid, operation, request_words, block_start, output ready);
endinterface

### hdl/ffsa_rsp_if.sv
// response channel: granted start word and status
`timescale 1ns / 1ps
interface ffsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [12:0] granted_start;
  logic [1:0]  status;

  modport source (output valid, granted_start, status, input ready);
  modport sink   (input valid, granted_start, status, output ready);
endinterface

### hdl/ffsa_cell.sv
// one segment table entry of the cell chain
`timescale 1ns / 1ps
module ffsa_cell
  import ffsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  entry_t           down,
  input  entry_t           up,
  input  entry_t           up2,
  output entry_t           ent
);

  entry_t ent_next;
  logic   at_pos;
  logic   above_pos;
  logic   at_pos1;

  assign at_pos    = (idx == ctl.pos);
  assign above_pos = (idx > ctl.pos);
  assign at_pos1   = ({1'b0, idx} == ({1'b0, ctl.pos} + (IDX_W + 1)'(1)));

  always_comb begin
    ent_next = ent;
    case (ctl.cmd)
      CC_HOLD:   ent_next = ent;
      CC_ROTATE: ent_next = up;
      CC_WRITE:  if (at_pos) ent_next = ctl.ent_a;
      CC_SPLIT: begin
        if (at_pos) ent_next = ctl.ent_a;
        else if (at_pos1) ent_next = ctl.ent_b;
        else if (above_pos) ent_next = down;
      end
      CC_MERGE: begin
        if (at_pos) ent_next = ctl.ent_a;
        else if (above_pos && ctl.shift == 2'd1) ent_next = up;
        else if (above_pos && ctl.shift == 2'd2) ent_next = up2;
      end
      default:   ent_next = ent;
    endcase
  end

  // used mark has a reset value, start and length do not
  always_ff @(posedge clk) begin
    ent.start <= ent_next.start;
    ent.len   <= ent_next.len;
    if (rst) begin
      ent.used <= 1'b0;
    end else begin
      ent.used <= ent_next.used;
    end
  end

endmodule

### hdl/ffsa_ctrl.sv
// sequencer: table scan through the rotating chain, edit decision, response register
`timescale 1ns / 1ps
module ffsa_ctrl
  import ffsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ffsa_req_if.sink          req,
  ffsa_rsp_if.source        rsp,
  input  entry_t            head,
  output cell_ctl_t         ctl
);

  state_t state, state_next;

  logic [CNT_W-1:0]   count, count_next;
  logic [LEN_W-1:0]   tail, tail_next;
  logic [IDX_W-1:0]   scnt;

  op_t                op;
  logic [LEN_W-1:0]   size;
  logic [START_W-1:0] addr;

  logic               found, grab;
  logic [IDX_W-1:0]   fi;
  logic [START_W-1:0] fst, pst;
  logic [LEN_W-1:0]   fln, pln, nln;
  logic               pf, nfree;
  logic               last_used;
  logic [START_W-1:0] last_start;
  logic [LEN_W-1:0]   last_len;

  logic [START_W-1:0] res_g, res_g_next;
  status_t            res_s, res_s_next;

  logic               in_tab;
  logic               hit;
  logic               tab_full;
  logic               is_last;
  logic [LEN_W-1:0]   room;
  logic [LEN_W-1:0]   mlen;
  logic [1:0]         dcnt;

  assign in_tab   = ({1'b0, scnt} < count);
  assign tab_full = (count == CNT_W'(MAX_SEGMENTS));
  assign is_last  = (({1'b0, fi} + CNT_W'(1)) == count);
  assign room     = LEN_W'(POOL_WORDS) - tail;
  assign dcnt     = {1'b0, nfree} + {1'b0, pf};
  assign mlen     = fln + (nfree ? nln : '0) + (pf ? pln : '0);

  always_comb begin
    if (op == OP_ALLOC) begin
      hit = in_tab && !found && !head.used && (head.len >= size);
    end else begin
      hit = in_tab && !found && head.used && (head.start == addr);
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, cell commands and the edit decision
  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.cmd      = CC_HOLD;
    count_next   = count;
    tail_next    = tail;
    res_g_next   = res_g;
    res_s_next   = res_s;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.cmd = CC_ROTATE;
        if (scnt == IDX_W'(MAX_SEGMENTS - 1)) state_next = S_EDIT;
      end
      S_EDIT: begin
        state_next = S_DONE;
        res_g_next = '0;
        res_s_next = ST_OK;
        if (op == OP_ALLOC) begin
          if (size == '0) begin
            res_s_next = ST_NO_SPACE;
          end else if (found) begin
            if (fln == size) begin
              ctl.cmd   = CC_WRITE;
              ctl.pos   = fi;
              ctl.ent_a = '{start: fst, len: fln, used: 1'b1};
              res_g_next = fst;
            end else if (tab_full) begin
              res_s_next = ST_TABLE_FULL;
            end else begin
              ctl.cmd   = CC_SPLIT;
              ctl.pos   = fi;
              ctl.ent_a = '{start: fst, len: size, used: 1'b1};
              ctl.ent_b = '{start: fst + size[START_W-1:0], len: fln - size, used: 1'b0};
              count_next = count + CNT_W'(1);
              res_g_next = fst;
            end
          end else if (room < size) begin
            res_s_next = ST_NO_SPACE;
          end else if (tab_full) begin
            res_s_next = ST_TABLE_FULL;
          end else begin
            ctl.cmd   = CC_WRITE;
            ctl.pos   = count[IDX_W-1:0];
            ctl.ent_a = '{start: tail[START_W-1:0], len: size, used: 1'b1};
            count_next = count + CNT_W'(1);
            tail_next  = tail + size;
            res_g_next = tail[START_W-1:0];
          end
        end else begin
          if (!found) begin
            res_s_next = ST_NOT_FOUND;
          end else if (is_last) begin
            // freed block ends the table: it and a free predecessor go back to the tail
            tail_next  = {1'b0, (pf ? pst : fst)};
            count_next = count - (pf ? CNT_W'(2) : CNT_W'(1));
          end else begin
            ctl.cmd   = CC_MERGE;
            ctl.pos   = pf ? (fi - IDX_W'(1)) : fi;
            ctl.ent_a = '{start: (pf ? pst : fst), len: mlen, used: 1'b0};
            ctl.shift = dcnt;
            count_next = count - CNT_W'(dcnt);
          end
        end
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      tail  <= '0;
    end else begin
      count <= count_next;
      tail  <= tail_next;
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      grab  <= 1'b0;
      nfree <= 1'b0;
      scnt  <= '0;
    end else if (state == S_IDLE && req.valid) begin
      found <= 1'b0;
      grab  <= 1'b0;
      nfree <= 1'b0;
      scnt  <= '0;
    end else if (state == S_SCAN) begin
      scnt <= scnt + IDX_W'(1);
      if (hit) begin
        found <= 1'b1;
        grab  <= 1'b1;
      end else if (grab) begin
        grab  <= 1'b0;
        nfree <= in_tab && !head.used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op   <= op_t'(req.operation);
      size <= req.request_words;
      addr <= req.block_start;
    end
    if (state == S_SCAN) begin
      last_used  <= head.used;
      last_start <= head.start;
      last_len   <= head.len;
      if (hit) begin
        fi  <= scnt;
        fst <= head.start;
        fln <= head.len;
        pf  <= (scnt != '0) && !last_used;
        pst <= last_start;
        pln <= last_len;
      end
      if (!hit && grab) nln <= head.len;
    end
    res_g <= res_g_next;
    res_s <= res_s_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.granted_start <= res_g;
      rsp.status        <= res_s;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above table size");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= LEN_W'(POOL_WORDS))
    else $error("tail pointer beyond pool");

  a_count_edit: assert property (@(posedge clk) disable iff (rst)
    state != S_EDIT |=> $stable(count) && $stable(tail))
    else $error("table bookkeeping changed outside edit step");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.granted_start == '0)
    else $error("error response with nonzero start");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second beat taken during scan");

endmodule

### hdl/first_fit_segment_allocator_top.sv
// first-fit segment allocator: cell chain holding the segment table plus its sequencer
// a request passes from the request beat to the response beat through 32 rotation
// steps of the cell chain, one edit step and one response load
// one request at a time: ready stays low until the response is loaded, also while a response stalls
// reset: synchronous, active high; table empty, tail at word 0, all used marks clear
`timescale 1ns / 1ps
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ffsa_req_if.sink   req,
  ffsa_rsp_if.source rsp
);

  // the chain: cell k sees k-1, k+1 and k+2; it wraps so a rotation
  // brings every entry past cell 0 and back into place
  entry_t    ent [MAX_SEGMENTS];
  cell_ctl_t ctl;

  ffsa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .head (ent[0]),
    .ctl  (ctl)
  );

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    ffsa_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (IDX_W'(k)),
      .ctl  (ctl),
      .down (ent[(k + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
      .up   (ent[(k + 1) % MAX_SEGMENTS]),
      .up2  (ent[(k + 2) % MAX_SEGMENTS]),
      .ent  (ent[k])
    );
  end

endmodule
